FILE: rtl/core/ucfve_pkg.sv
// Package for the unit cube face vertex emitter.
// Holds item, result and job types, register indexes and the UV and corner tables.
// No dependencies.
package ucfve_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Z = 2'd2;

	localparam logic signed [32:0] LOCAL_MIN = -33'sd32768;
	localparam logic signed [32:0] LOCAL_MAX = 33'sd32766;

	localparam logic [2:0] NUM_SIDES = 3'd6;
	localparam logic [2:0] LAST_CORNER = 3'd5;

	typedef struct packed {
		logic [2:0]         side;
		logic signed [31:0] block_x;
		logic signed [31:0] block_y;
		logic signed [31:0] block_z;
		logic [7:0]         tile;
		logic [31:0]        face_color;
		logic [31:0]        face_brightness;
	} item_t;

	typedef struct packed {
		logic               accepted;
		logic [31:0]        vertex_number;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [31:0]        tex_u;
		logic [31:0]        tex_v;
		logic [31:0]        vert_color;
		logic [31:0]        vert_brightness;
		logic               last;
	} result_t;

	typedef struct packed {
		logic               ok;
		logic [2:0]         side;
		logic signed [15:0] lx;
		logic signed [15:0] ly;
		logic signed [15:0] lz;
		logic [3:0]         col;
		logic [3:0]         row;
		logic [31:0]        color;
		logic [31:0]        bright;
	} job_t;

	// corner code: bit0 +x, bit1 +y, bit2 +z, bit3 high u, bit4 high v
	typedef logic [0:5][4:0] corner_row_t;

	localparam corner_row_t CORNER_TBL [6] = '{
		'{5'd20, 5'd0,  5'd9,  5'd20, 5'd9,  5'd29},
		'{5'd31, 5'd11, 5'd2,  5'd31, 5'd2,  5'd22},
		'{5'd10, 5'd3,  5'd17, 5'd10, 5'd17, 5'd24},
		'{5'd6,  5'd20, 5'd29, 5'd6,  5'd29, 5'd15},
		'{5'd14, 5'd2,  5'd16, 5'd14, 5'd16, 5'd28},
		'{5'd21, 5'd25, 5'd11, 5'd21, 5'd11, 5'd7}
	};

	function automatic logic [31:0] edge_lo(input logic [3:0] n);
		logic [31:0] r;
		case (n)
			4'd0:    r = 32'h00000000;
			4'd1:    r = 32'h3D800000;
			4'd2:    r = 32'h3E000000;
			4'd3:    r = 32'h3E400000;
			4'd4:    r = 32'h3E800000;
			4'd5:    r = 32'h3EA00000;
			4'd6:    r = 32'h3EC00000;
			4'd7:    r = 32'h3EE00000;
			4'd8:    r = 32'h3F000000;
			4'd9:    r = 32'h3F100000;
			4'd10:   r = 32'h3F200000;
			4'd11:   r = 32'h3F300000;
			4'd12:   r = 32'h3F400000;
			4'd13:   r = 32'h3F500000;
			4'd14:   r = 32'h3F600000;
			default: r = 32'h3F700000;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] edge_hi(input logic [3:0] n);
		logic [31:0] r;
		case (n)
			4'd0:    r = 32'h3D7FD70A;
			4'd1:    r = 32'h3DFFEB85;
			4'd2:    r = 32'h3E3FF5C3;
			4'd3:    r = 32'h3E7FF5C3;
			4'd4:    r = 32'h3E9FFAE1;
			4'd5:    r = 32'h3EBFFAE1;
			4'd6:    r = 32'h3EDFFAE1;
			4'd7:    r = 32'h3EFFFAE1;
			4'd8:    r = 32'h3F0FFD71;
			4'd9:    r = 32'h3F1FFD71;
			4'd10:   r = 32'h3F2FFD71;
			4'd11:   r = 32'h3F3FFD71;
			4'd12:   r = 32'h3F4FFD71;
			4'd13:   r = 32'h3F5FFD71;
			4'd14:   r = 32'h3F6FFD71;
			default: r = 32'h3F7FFD71;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/ucfve_front.sv
// Front stage: origin registers, accept of face items, local position and range check.
// Depends on ucfve_pkg; feeds ucfve_queue.
module ucfve_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  ucfve_pkg::item_t                  item,
	output logic                              full,
	input  logic                              cfg_we,
	input  logic [ucfve_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [ucfve_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output logic                              job_valid,
	output ucfve_pkg::job_t                   job,
	input  logic                              job_full
);
	import ucfve_pkg::*;

	logic signed [31:0] origin_x_q, origin_y_q, origin_z_q;
	logic signed [32:0] dx, dy, dz;
	logic               ok;
	logic               advance;
	logic               valid_s1;
	job_t               job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ORIGIN_X: origin_x_q <= cfg_wdata;
				REG_ORIGIN_Y: origin_y_q <= cfg_wdata;
				REG_ORIGIN_Z: origin_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign dx = {item.block_x[31], item.block_x} - {origin_x_q[31], origin_x_q};
	assign dy = {item.block_y[31], item.block_y} - {origin_y_q[31], origin_y_q};
	assign dz = {item.block_z[31], item.block_z} - {origin_z_q[31], origin_z_q};

	assign ok = (item.side < NUM_SIDES)
		&& (dx >= LOCAL_MIN) && (dx <= LOCAL_MAX)
		&& (dy >= LOCAL_MIN) && (dy <= LOCAL_MAX)
		&& (dz >= LOCAL_MIN) && (dz <= LOCAL_MAX);

	assign advance = !valid_s1 || !job_full;
	assign full    = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push) begin
			job_s1.ok     <= ok;
			job_s1.side   <= item.side;
			job_s1.lx     <= dx[15:0];
			job_s1.ly     <= dy[15:0];
			job_s1.lz     <= dz[15:0];
			job_s1.col    <= item.tile[3:0];
			job_s1.row    <= item.tile[7:4];
			job_s1.color  <= item.face_color;
			job_s1.bright <= item.face_brightness;
		end
	end

	assign job_valid = valid_s1;
	assign job       = job_s1;

endmodule

FILE: rtl/core/ucfve_queue.sv
// Short job queue between the front and back stages.
// Depends on ucfve_pkg for the job type.
module ucfve_queue #(
	parameter int DEPTH = ucfve_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  ucfve_pkg::job_t  wr_data,
	output logic             full,
	input  logic             rd_en,
	output ucfve_pkg::job_t  rd_data,
	output logic             not_empty
);
	import ucfve_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/ucfve_back.sv
// Back stage: corner sequencer, vertex numbering and the result register.
// Depends on ucfve_pkg; reads jobs from ucfve_queue.
module ucfve_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	input  ucfve_pkg::job_t      job,
	output logic                 job_pop,
	output logic                 empty,
	input  logic                 pop,
	output ucfve_pkg::result_t   result
);
	import ucfve_pkg::*;

	logic [2:0]  corner_q;
	logic [31:0] vertex_total_q;
	logic        out_valid_q;
	result_t     res_q;
	logic        produce;
	logic        last_vert;
	logic [4:0]  code;
	corner_row_t row_codes;
	result_t     res_next;

	assign produce   = job_valid && (!out_valid_q || pop);
	assign last_vert = (corner_q == LAST_CORNER);
	assign job_pop   = produce && (!job.ok || last_vert);
	assign row_codes = CORNER_TBL[job.side];
	assign code      = row_codes[corner_q];

	always_comb begin
		res_next = '0;
		res_next.last = 1'b1;
		if (job.ok) begin
			res_next.accepted        = 1'b1;
			res_next.vertex_number   = vertex_total_q;
			res_next.pos_x           = job.lx + 16'(code[0]);
			res_next.pos_y           = job.ly + 16'(code[1]);
			res_next.pos_z           = job.lz + 16'(code[2]);
			res_next.tex_u           = code[3] ? edge_hi(job.col) : edge_lo(job.col);
			res_next.tex_v           = code[4] ? edge_hi(job.row) : edge_lo(job.row);
			res_next.vert_color      = job.color;
			res_next.vert_brightness = job.bright;
			res_next.last            = last_vert;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q       <= '0;
			vertex_total_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (produce) begin
				out_valid_q <= 1'b1;
				if (job.ok) begin
					corner_q <= last_vert ? '0 : corner_q + 1'b1;
					if (vertex_total_q != '1) begin
						vertex_total_q <= vertex_total_q + 1'b1;
					end
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			res_q <= res_next;
		end
	end

	assign empty  = !out_valid_q;
	assign result = res_q;

endmodule

FILE: rtl/core/unit_cube_face_vertex_emitter.sv
// Top level of the unit cube face vertex emitter.
// Instantiates ucfve_front, ucfve_queue and ucfve_back; depends on ucfve_pkg.
//
// Input channel: an item is taken at a clock edge with push high and full low.
// Result channel: the oldest result sits on result while empty is low and is
// taken at an edge with pop high and empty low.
// Configuration: origin_x/y/z are written at an edge with cfg_we high, index
// on cfg_addr, value on cfg_wdata; write only while the block is idle.
// The first result of a face passes the front register, the job queue and
// the result register. An accepted face gives six vertices and a rejected
// face one result; the back sequencer issues one result per cycle into a
// single result register while pop keeps that register drained.
// Items keep being taken while earlier faces are still being emitted, until
// the job queue (QUEUE_DEPTH entries) and the front register are full.
// When pop stays low the result holds, the sequencer stalls and the queue
// fills, then full rises. Reset clears the origins, the vertex count, the
// queue and all valid flags; no clearing pass is needed.
module unit_cube_face_vertex_emitter #(
	parameter int QUEUE_DEPTH = ucfve_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  ucfve_pkg::item_t                  item,
	output logic                              full,
	output logic                              empty,
	input  logic                              pop,
	output ucfve_pkg::result_t                result,
	input  logic                              cfg_we,
	input  logic [ucfve_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [ucfve_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import ucfve_pkg::*;

	logic front_valid;
	job_t front_job;
	logic q_full;
	logic q_not_empty;
	job_t q_job;
	logic q_pop;

	ucfve_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.job_valid (front_valid),
		.job       (front_job),
		.job_full  (q_full)
	);

	ucfve_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (front_valid),
		.wr_data   (front_job),
		.full      (q_full),
		.rd_en     (q_pop),
		.rd_data   (q_job),
		.not_empty (q_not_empty)
	);

	ucfve_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_not_empty),
		.job       (q_job),
		.job_pop   (q_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
